// File: design/tlg_pkg.sv
// Shared constants for the tile layout generator: field widths, register
// indexes, layout mode codes and default register values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlg_pkg;

    // field widths
    localparam int COUNT_W = 7;
    localparam int COORD_W = 16;
    localparam int TILE_XY_W = 18;
    localparam int DIM_W = 16;
    localparam int PAD_W = 15;
    localparam int MODE_W = 2;
    localparam int INDEX_W = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // default tile limit
    localparam int MAX_TILES_DEF = 64;

    // smallest count that gets a real grid
    localparam logic [COUNT_W-1:0] GRID_MIN = 7'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_AMOUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT_MODE = 3'd5;

    // layout modes (any other code lays out columns)
    localparam logic [MODE_W-1:0] MODE_COLUMNS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROWS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GRID = 2'd2;

    // register reset values
    localparam logic [DIM_W-1:0] BOUND_WIDTH_RST = 16'd1920;
    localparam logic [DIM_W-1:0] BOUND_HEIGHT_RST = 16'd1080;

endpackage

`default_nettype wire

// File: design/tile_layout_generator.sv
// Sequence from an accepted request to its first tile: a square root search
// in grid mode, three divisions on one shared restoring divider (rows, tile
// width, tile height), a padding step, then the load of the output
// register; tiles then leave one per cycle while the output is taken.
// The padding step waits while a tile of the previous request is still held.
// A new request is taken only once the last tile of the previous one is loaded
// into the output register; a request with a zero count leaves the block idle.
// Reset (synchronous, active low) restores register defaults and goes idle.
// Depends on tlg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tile_layout_generator
    import tlg_pkg::*;
#(
    parameter int MAX_TILES = MAX_TILES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        i_cfg_data,
    // request channel
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [COUNT_W-1:0]           i_tile_count,
    // tile channel
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [TILE_XY_W-1:0]       o_tile_x,
    output logic signed [TILE_XY_W-1:0]       o_tile_y,
    output logic [DIM_W-1:0]                  o_tile_width,
    output logic [DIM_W-1:0]                  o_tile_height,
    output logic [INDEX_W-1:0]                o_tile_index,
    output logic                              o_last_tile
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLS,
        ST_DIV_ROWS,
        ST_DIV_W,
        ST_DIV_H,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam int DIV_CNT_W = $clog2(DIM_W);

    // configuration registers
    logic [COORD_W-1:0]   r_bound_x;
    logic [COORD_W-1:0]   r_bound_y;
    logic [DIM_W-1:0]     r_bound_width;
    logic [DIM_W-1:0]     r_bound_height;
    logic [PAD_W-1:0]     r_pad_amount;
    logic [MODE_W-1:0]    r_layout_mode;

    // sequencer state
    t_state               r_state;
    logic [COUNT_W-1:0]   r_n;
    logic [3:0]           r_sq;
    logic [COUNT_W-1:0]   r_cols;
    logic [COUNT_W-1:0]   r_rows;
    logic [DIM_W-1:0]     r_w;
    logic [DIM_W-1:0]     r_h;

    // shared divider
    logic [DIM_W-1:0]     r_quo;
    logic [COUNT_W-1:0]   r_rem;
    logic [COUNT_W-1:0]   r_dsr;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // emit counters
    logic [INDEX_W-1:0]   r_idx;
    logic [COUNT_W-1:0]   r_col;
    logic [DIM_W-1:0]     r_xoff;
    logic [DIM_W-1:0]     r_yoff;

    // output registers
    logic                       r_o_valid;
    logic [TILE_XY_W-1:0]       r_o_x;
    logic [TILE_XY_W-1:0]       r_o_y;
    logic [DIM_W-1:0]           r_o_w;
    logic [DIM_W-1:0]           r_o_h;
    logic [INDEX_W-1:0]         r_o_idx;
    logic                       r_o_last;

    // combinational helpers
    logic [COUNT_W-1:0]   n_count;
    logic [3:0]           n_sq1;
    logic [7:0]           n_sq1_sq;
    logic                 n_grid;
    logic [COUNT_W-1:0]   n_cols;
    logic [COUNT_W:0]     n_ceil_num;
    logic [COUNT_W:0]     n_trial;
    logic                 n_ge;
    logic [COUNT_W-1:0]   n_rem;
    logic [DIM_W-1:0]     n_quo;
    logic                 n_div_done;
    logic [DIM_W:0]       n_pad2;
    logic                 n_out_free;
    logic                 n_last;

    // request count, saturated to the tile limit
    assign n_count = (i_tile_count > COUNT_W'(MAX_TILES)) ? COUNT_W'(MAX_TILES)
                                                          : i_tile_count;

    // floor square root search: step while (r+1)^2 fits in n
    assign n_sq1    = r_sq + 4'd1;
    assign n_sq1_sq = {4'd0, n_sq1} * {4'd0, n_sq1};
    assign n_grid   = (r_layout_mode == MODE_GRID) && (r_n >= GRID_MIN);
    assign n_cols   = (r_layout_mode == MODE_ROWS) ? COUNT_W'(1) : r_n;

    // rows = ceil(n / cols) for every mode (1 for columns, n for rows)
    assign n_ceil_num = {1'b0, r_n} + {1'b0, (n_grid ? {3'd0, r_sq} : n_cols)}
                        - (COUNT_W+1)'(1);

    // one restoring division step
    assign n_trial    = {r_rem, r_quo[DIM_W-1]};
    assign n_ge       = n_trial >= {1'b0, r_dsr};
    assign n_rem      = n_ge ? COUNT_W'(n_trial - {1'b0, r_dsr}) : n_trial[COUNT_W-1:0];
    assign n_quo      = {r_quo[DIM_W-2:0], n_ge};
    assign n_div_done = (r_div_cnt == DIV_CNT_W'(DIM_W - 1));

    assign n_pad2     = {1'b0, r_pad_amount, 1'b0};
    assign n_out_free = !r_o_valid || i_ready;
    assign n_last     = ({1'b0, r_idx} + COUNT_W'(1)) == r_n;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_x      <= '0;
            r_bound_y      <= '0;
            r_bound_width  <= BOUND_WIDTH_RST;
            r_bound_height <= BOUND_HEIGHT_RST;
            r_pad_amount   <= '0;
            r_layout_mode  <= MODE_COLUMNS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BOUND_X:      r_bound_x      <= i_cfg_data;
                REG_BOUND_Y:      r_bound_y      <= i_cfg_data;
                REG_BOUND_WIDTH:  r_bound_width  <= i_cfg_data;
                REG_BOUND_HEIGHT: r_bound_height <= i_cfg_data;
                REG_PAD_AMOUNT:   r_pad_amount   <= i_cfg_data[PAD_W-1:0];
                REG_LAYOUT_MODE:  r_layout_mode  <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, shared divider and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // output valid: load a tile when free, else drop once taken
            if ((r_state == ST_EMIT) && n_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_n  <= n_count;
                        r_sq <= 4'd1;
                        if (n_count != '0) begin
                            r_state <= ST_COLS;
                        end
                    end
                end
                ST_COLS: begin
                    if (n_grid && ({1'b0, n_sq1_sq[COUNT_W-1:0]} <= {1'b0, r_n})
                            && !n_sq1_sq[7]) begin
                        r_sq <= n_sq1;
                    end else begin
                        r_cols    <= n_grid ? {3'd0, r_sq} : n_cols;
                        r_dsr     <= n_grid ? {3'd0, r_sq} : n_cols;
                        r_quo     <= {{(DIM_W-COUNT_W){1'b0}}, n_ceil_num[COUNT_W-1:0]};
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_state   <= ST_DIV_ROWS;
                    end
                end
                ST_DIV_ROWS: begin
                    if (n_div_done) begin
                        r_rows    <= n_quo[COUNT_W-1:0];
                        r_quo     <= r_bound_width;
                        r_rem     <= '0;
                        r_dsr     <= r_cols;
                        r_div_cnt <= '0;
                        r_state   <= ST_DIV_W;
                    end else begin
                        r_quo     <= n_quo;
                        r_rem     <= n_rem;
                        r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    end
                end
                ST_DIV_W: begin
                    if (n_div_done) begin
                        r_w       <= n_quo;
                        r_quo     <= r_bound_height;
                        r_rem     <= '0;
                        r_dsr     <= r_rows;
                        r_div_cnt <= '0;
                        r_state   <= ST_DIV_H;
                    end else begin
                        r_quo     <= n_quo;
                        r_rem     <= n_rem;
                        r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    end
                end
                ST_DIV_H: begin
                    if (n_div_done) begin
                        r_h     <= n_quo;
                        r_state <= ST_PAD;
                    end else begin
                        r_quo     <= n_quo;
                        r_rem     <= n_rem;
                        r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    end
                end
                ST_PAD: begin
                    // wait until a held tile of the previous request is gone
                    if (n_out_free) begin
                        // shrink only when both sides exceed twice the padding
                        if (({1'b0, r_w} > n_pad2) && ({1'b0, r_h} > n_pad2)) begin
                            r_o_w <= DIM_W'({1'b0, r_w} - n_pad2);
                            r_o_h <= DIM_W'({1'b0, r_h} - n_pad2);
                        end else begin
                            r_o_w <= r_w;
                            r_o_h <= r_h;
                        end
                        r_idx   <= '0;
                        r_col   <= '0;
                        r_xoff  <= '0;
                        r_yoff  <= '0;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (n_out_free) begin
                        r_o_x     <= {{2{r_bound_x[COORD_W-1]}}, r_bound_x}
                                     + {2'b00, r_xoff};
                        r_o_y     <= {{2{r_bound_y[COORD_W-1]}}, r_bound_y}
                                     + {2'b00, r_yoff};
                        r_o_idx   <= r_idx;
                        r_o_last  <= n_last;
                        r_idx     <= r_idx + INDEX_W'(1);
                        // row-major walk: wrap at the last column
                        if ((r_col + COUNT_W'(1)) == r_cols) begin
                            r_col  <= '0;
                            r_xoff <= '0;
                            r_yoff <= r_yoff + r_h;
                        end else begin
                            r_col  <= r_col + COUNT_W'(1);
                            r_xoff <= r_xoff + r_w;
                        end
                        if (n_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_tile_x      = r_o_x;
    assign o_tile_y      = r_o_y;
    assign o_tile_width  = r_o_w;
    assign o_tile_height = r_o_h;
    assign o_tile_index  = r_o_idx;
    assign o_last_tile   = r_o_last;

    // column walk never passes the column count
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_col < r_cols))
        else $error("column counter past column count");

    // no division is ever run by zero
    a_dsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_ROWS || r_state == ST_DIV_W || r_state == ST_DIV_H)
        |-> (r_dsr != '0))
        else $error("divider started with a zero divisor");

    // a tile load always follows a request that was accepted with a nonzero count
    a_emit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_n != '0) && ({1'b0, r_idx} < r_n))
        else $error("tile index past requested count");

endmodule

`default_nettype wire

// File: tb/sv/tb_tile_layout_generator.sv
// Self-checking testbench for tile_layout_generator: drives tile count requests
// and register writes, predicts every tile and checks the tile stream in order.
// Depends on tlg_pkg and tile_layout_generator.
`timescale 1ns / 1ps

module tb_tile_layout_generator;
    import tlg_pkg::*;

    localparam int TILE_LIMIT = MAX_TILES_DEF;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT = 18;
    localparam int RANDOM_PER_PHASE = 47;

    // register indexes the block ignores, and the mode code it treats as columns
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct {
        logic [TILE_XY_W-1:0] x;
        logic [TILE_XY_W-1:0] y;
        logic [DIM_W-1:0]     w;
        logic [DIM_W-1:0]     h;
        logic [INDEX_W-1:0]   idx;
        logic                 last;
    } tile_t;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [COUNT_W-1:0]           i_tile_count = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic signed [TILE_XY_W-1:0]  o_tile_x;
    logic signed [TILE_XY_W-1:0]  o_tile_y;
    logic [DIM_W-1:0]             o_tile_width;
    logic [DIM_W-1:0]             o_tile_height;
    logic [INDEX_W-1:0]           o_tile_index;
    logic                         o_last_tile;

    // shadow copy of the layout registers
    logic signed [COORD_W-1:0] lay_x = '0;
    logic signed [COORD_W-1:0] lay_y = '0;
    logic [DIM_W-1:0]          lay_w = BOUND_WIDTH_RST;
    logic [DIM_W-1:0]          lay_h = BOUND_HEIGHT_RST;
    logic [PAD_W-1:0]          lay_pad = '0;
    logic [MODE_W-1:0]         lay_mode = MODE_COLUMNS;

    logic [COUNT_W-1:0] counts_pending[$];
    tile_t              tiles_due[$];
    tile_t              head;

    logic req_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic calm = 1'b0;
    int   hold_req = 0;
    int   hold_ack = 0;
    int   hold_left = 0;
    int   idle_cycles = 0;
    int   mismatches = 0;
    int   req_total = 0;
    int   empty_total = 0;
    int   over_total = 0;
    int   tile_total = 0;
    int   cfg_total = 0;
    int   mode_hits[4] = '{0, 0, 0, 0};

    tile_layout_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_tile_count  (i_tile_count),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_tile_x      (o_tile_x),
        .o_tile_y      (o_tile_y),
        .o_tile_width  (o_tile_width),
        .o_tile_height (o_tile_height),
        .o_tile_index  (o_tile_index),
        .o_last_tile   (o_last_tile)
    );

    always #10 i_clk = ~i_clk;

    // expected tiles for one request under the current register copy
    function automatic void lay_out_tiles(logic [COUNT_W-1:0] count);
        int    n, cols, rows, w, h, pad2, x, y, tw, th;
        tile_t t;
        n = (count > TILE_LIMIT) ? TILE_LIMIT : count;
        if (n == 0)
            return;
        if (lay_mode == MODE_ROWS) begin
            cols = 1;
            w = lay_w;
            h = lay_h / n;
        end else if (lay_mode == MODE_GRID && n >= GRID_MIN) begin
            // exact integer square root
            cols = 0;
            while ((cols + 1) * (cols + 1) <= n)
                cols++;
            rows = (n + cols - 1) / cols;
            w = lay_w / cols;
            h = lay_h / rows;
        end else begin
            cols = n;
            w = lay_w / n;
            h = lay_h;
        end
        pad2 = 2 * lay_pad;
        for (int i = 0; i < n; i++) begin
            x = lay_x + (i % cols) * w;
            y = lay_y + (i / cols) * h;
            tw = w;
            th = h;
            // padding only when both sides stay positive
            if (tw > pad2 && th > pad2) begin
                tw -= pad2;
                th -= pad2;
            end
            t.x = x[TILE_XY_W-1:0];
            t.y = y[TILE_XY_W-1:0];
            t.w = tw[DIM_W-1:0];
            t.h = th[DIM_W-1:0];
            t.idx = i[INDEX_W-1:0];
            t.last = (i + 1 == n);
            tiles_due.push_back(t);
        end
    endfunction

    // request driver: next count from the pending queue, random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (counts_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                i_tile_count <= counts_pending.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_tile_count <= COUNT_W'($urandom);
                i_valid <= 1'b0;
            end
        end
    end

    // tile receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: register copy, prediction, tile checks, watchdog
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && i_valid && o_ready;
        cfg_taken <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                tile_total++;
                if (tiles_due.size() == 0) begin
                    $error("tile with no request behind it: index %0d", o_tile_index);
                    mismatches++;
                end else begin
                    head = tiles_due.pop_front();
                    if (o_tile_x !== head.x) begin
                        $error("tile_x: expected %0d, got %0d", $signed(head.x), o_tile_x);
                        mismatches++;
                    end
                    if (o_tile_y !== head.y) begin
                        $error("tile_y: expected %0d, got %0d", $signed(head.y), o_tile_y);
                        mismatches++;
                    end
                    if (o_tile_width !== head.w) begin
                        $error("tile_width: expected %0d, got %0d", head.w, o_tile_width);
                        mismatches++;
                    end
                    if (o_tile_height !== head.h) begin
                        $error("tile_height: expected %0d, got %0d", head.h, o_tile_height);
                        mismatches++;
                    end
                    if (o_tile_index !== head.idx) begin
                        $error("tile_index: expected %0d, got %0d", head.idx, o_tile_index);
                        mismatches++;
                    end
                    if (o_last_tile !== head.last) begin
                        $error("last_tile: expected %0d, got %0d", head.last, o_last_tile);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_total++;
                case (i_cfg_index)
                    REG_BOUND_X: lay_x = i_cfg_data;
                    REG_BOUND_Y: lay_y = i_cfg_data;
                    REG_BOUND_WIDTH: lay_w = i_cfg_data;
                    REG_BOUND_HEIGHT: lay_h = i_cfg_data;
                    REG_PAD_AMOUNT: lay_pad = i_cfg_data[PAD_W-1:0];
                    REG_LAYOUT_MODE: lay_mode = i_cfg_data[MODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                req_total++;
                if (i_tile_count == 0)
                    empty_total++;
                if (i_tile_count > TILE_LIMIT)
                    over_total++;
                mode_hits[lay_mode]++;
                lay_out_tiles(i_tile_count);
            end
            // watchdog on cycles with no handshake at all
            if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // one register write, held until taken
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for all requests and tiles, then let a trailing empty request finish
    task automatic drain();
        while (counts_pending.size() != 0 || i_valid || tiles_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random counts: some empty, some above the limit, the rest in range
    task automatic queue_random(input int num);
        int pick;
        for (int k = 0; k < num; k++) begin
            pick = $urandom_range(99);
            if (pick < 8)
                counts_pending.push_back('0);
            else if (pick < 16)
                counts_pending.push_back(COUNT_W'($urandom_range(127, TILE_LIMIT + 1)));
            else if (pick < 26)
                counts_pending.push_back(COUNT_W'(TILE_LIMIT));
            else
                counts_pending.push_back(COUNT_W'($urandom_range(TILE_LIMIT - 1, 1)));
        end
    endtask

    task automatic random_setup();
        write_reg(REG_BOUND_X, CFG_DATA_W'($urandom));
        write_reg(REG_BOUND_Y, CFG_DATA_W'($urandom));
        write_reg(REG_BOUND_WIDTH, ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                                            : CFG_DATA_W'($urandom_range(4000)));
        write_reg(REG_BOUND_HEIGHT, ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                                             : CFG_DATA_W'($urandom_range(4000)));
        write_reg(REG_PAD_AMOUNT, ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom)
                                                           : CFG_DATA_W'($urandom_range(60)));
        write_reg(REG_LAYOUT_MODE, CFG_DATA_W'($urandom));
    endtask

    initial begin
        logic [COUNT_W-1:0] directed[6] = '{7'd1, 7'd3, 7'd4, 7'd10, 7'd64, 7'd127};
        logic [MODE_W-1:0]  modes[4] = '{MODE_COLUMNS, MODE_ROWS, MODE_GRID, MODE_SPARE};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every mode at the reset bounds, empty and saturated counts
        for (int m = 0; m < 4; m++) begin
            if (m != 0)
                write_reg(REG_LAYOUT_MODE, CFG_DATA_W'(modes[m]));
            foreach (directed[k])
                counts_pending.push_back(directed[k]);
            if (m == 0) begin
                counts_pending.push_back('0);
                counts_pending.push_back(7'd65);
            end
            @(posedge i_clk);
            drain();
        end

        // extreme bounds, padding that swallows the tile, upper data bits ignored
        write_reg(REG_BOUND_X, 16'h8000);
        write_reg(REG_BOUND_Y, 16'h7FFF);
        write_reg(REG_BOUND_WIDTH, 16'hFFFF);
        write_reg(REG_BOUND_HEIGHT, 16'hFFFF);
        write_reg(REG_PAD_AMOUNT, 16'h0000);
        write_reg(REG_LAYOUT_MODE, CFG_DATA_W'(MODE_GRID));
        queue_random(RANDOM_PER_PHASE);
        @(posedge i_clk);
        // receiver holds off while requests keep coming
        hold_req++;
        drain();

        write_reg(REG_BOUND_X, 16'h7FFF);
        write_reg(REG_BOUND_Y, 16'h8000);
        write_reg(REG_BOUND_WIDTH, 16'h0000);
        write_reg(REG_PAD_AMOUNT, 16'hFFFF);
        write_reg(REG_LAYOUT_MODE, {14'h3FFF, MODE_ROWS});
        write_reg(REG_UNUSED_LO, 16'hFFFF);
        queue_random(RANDOM_PER_PHASE);
        drain();

        write_reg(REG_BOUND_WIDTH, 16'hFFFF);
        write_reg(REG_BOUND_HEIGHT, 16'h0000);
        write_reg(REG_PAD_AMOUNT, 16'h0001);
        write_reg(REG_LAYOUT_MODE, {14'h2AAA, MODE_GRID});
        write_reg(REG_UNUSED_HI, 16'h5A5A);
        queue_random(RANDOM_PER_PHASE);
        drain();

        // random bounds, padding and mode; one phase with no idling
        for (int p = 0; p < 5; p++) begin
            random_setup();
            calm = (p == 2);
            queue_random(RANDOM_PER_PHASE);
            drain();
            calm = 1'b0;
        end

        $display("Run covered %0d requests (%0d empty, %0d above the tile limit), %0d tiles, %0d register writes",
                 req_total, empty_total, over_total, tile_total, cfg_total);
        $display("Requests by mode code: columns %0d, rows %0d, grid %0d, spare %0d",
                 mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (mismatches == 0 && tiles_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
